[hw/rtl/hashed_timer_wheel_core_defines.svh]
// Assertion macros for the hashed timer wheel.
`ifndef HASHED_TIMER_WHEEL_CORE_DEFINES_SVH
`define HASHED_TIMER_WHEEL_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define HTW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/htw_pkg.sv]
// Constants and types shared by the hashed timer wheel.
package htw_pkg;

   localparam int BUCKETS          = 64;
   localparam int BKT_W            = $clog2(BUCKETS);
   localparam int TICK_W           = 40;
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
   localparam int MAX_RESULTS      = 16;
   localparam int KCNT_W           = $clog2(MAX_RESULTS + 1);
   localparam int SESS_ID_W        = 8;
   localparam int GEN_W            = 32;
   localparam int DEF_SLOTS        = 16;
   localparam int DEF_SESSIONS     = 256;

   localparam logic [1:0] REQ_SCHEDULE = 2'd0;
   localparam logic [1:0] REQ_CANCEL   = 2'd1;
   localparam logic [1:0] REQ_ADVANCE  = 2'd2;

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_REJECTED = 2'd1;
   localparam logic [1:0] KIND_EXPIRED  = 2'd2;
   localparam logic [1:0] KIND_NO_EXP   = 2'd3;

   typedef struct packed {
      logic [TICK_W-1:0]    due;
      logic [GEN_W-1:0]     gen;
      logic [SESS_ID_W-1:0] sess;
   } slot_type;

endpackage

[hw/rtl/hashed_timer_wheel_core.sv]
// Hashed timer wheel: timer buckets, session index and tick scan sequencer.
// Schedule and cancel: one response each.
// Advance: steps the tick and scans each filled slot of the bucket through the
// slot memory read, compare and write-back loop.
// A response stalled on rsp_tready holds the sequencer only when it must emit.
// Synchronous reset clears the sequencer, the tick, bucket fill and session bits.
`include "hashed_timer_wheel_core_defines.svh"
module hashed_timer_wheel_core #(
   parameter int SLOTS_PER_BUCKET = htw_pkg::DEF_SLOTS,
   parameter int SESSIONS         = htw_pkg::DEF_SESSIONS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // session [7:0], generation [39:8], deadline_tick [79:40]
   input  logic [79:0] req_tdata,
   // req_type [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // expired_session [7:0], expired_generation [39:8]
   output logic [39:0] rsp_tdata,
   // kind [1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [39:0] csr_wr_data
);
   import htw_pkg::*;

   localparam int IW     = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int FW     = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int SESS_N = (SESSIONS < 256) ? SESSIONS : 256;
   localparam int SW     = $clog2(SESS_N);
   localparam int PL_W   = BKT_W + IW;
   localparam int SLOT_D = BUCKETS << IW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DROP_PLACE, ST_DROP_FILL, ST_DROP_LAST, ST_DROP_MOVE,
      ST_FILE_FILL, ST_FILE_WR, ST_RESULT, ST_ADV_FILL, ST_ADV_START,
      ST_SCAN_RD, ST_SCAN_EV, ST_SCAN_END
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [7:0]          sess_ff, sess_in;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic [TICK_W-1:0]   dead_ff, dead_in;
   logic [TICK_W-1:0]   due_ff, due_in;
   logic [TICK_W-1:0]   cur_ff, cur_in;
   logic [BKT_W-1:0]    bucket_ff, bucket_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [1:0]          res_kind_ff, res_kind_in;
   logic [FW-1:0]       n_ff, n_in;
   logic [FW-1:0]       scan_ff, scan_in;
   logic [FW-1:0]       keep_ff, keep_in;
   logic [KCNT_W-1:0]   k_ff, k_in;
   logic                pend_vld_ff, pend_vld_in;
   logic [7:0]          pend_sess_ff, pend_sess_in;
   logic [GEN_W-1:0]    pend_gen_ff, pend_gen_in;
   logic [SESS_N-1:0]   present_ff, present_in;
   logic [BUCKETS-1:0]  fill_vld_ff, fill_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [7:0]          rsp_sess_ff, rsp_sess_in;
   logic [GEN_W-1:0]    rsp_gen_ff, rsp_gen_in;
   logic                rsp_last_ff, rsp_last_in;

   slot_type            slot_mem [SLOT_D];
   logic [PL_W-1:0]     place_mem [SESS_N];
   logic [FW-1:0]       fill_mem [BUCKETS];
   slot_type            slot_rd_ff;
   logic [PL_W-1:0]     place_rd_ff;
   logic [FW-1:0]       fill_rd_ff;

   logic                slot_re, slot_we, place_re, place_we, fill_re, fill_we;
   logic [PL_W-1:0]     slot_raddr, slot_waddr, place_wdata;
   slot_type            slot_wdata;
   logic [SW-1:0]       place_raddr, place_waddr;
   logic [BKT_W-1:0]    fill_raddr, fill_waddr;
   logic [FW-1:0]       fill_wdata;

   logic                out_free, expire, s_ok, moved_ok, exp_ok;
   logic [FW-1:0]       fill_cur, lastidx;
   logic [TICK_W-1:0]   floor_tick, due_calc;
   logic [7:0]          req_sess;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign fill_cur   = fill_vld_ff[bucket_ff] ? fill_rd_ff : '0;
   assign lastidx    = fill_cur - FW'(1);
   assign floor_tick = (cur_ff == TICK_MAX) ? TICK_MAX : cur_ff + TICK_W'(1);
   assign due_calc   = (dead_ff > floor_tick) ? dead_ff : floor_tick;
   assign expire     = (slot_rd_ff.due <= cur_ff) && (k_ff < KCNT_W'(MAX_RESULTS));
   assign req_sess   = req_tdata[7:0];
   assign s_ok       = 32'(sess_ff) < SESSIONS;
   assign moved_ok   = (32'(slot_rd_ff.sess) < SESSIONS) && present_ff[slot_rd_ff.sess[SW-1:0]];
   assign exp_ok     = 32'(slot_rd_ff.sess) < SESSIONS;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sess_in      = sess_ff;
      gen_in       = gen_ff;
      dead_in      = dead_ff;
      due_in       = due_ff;
      cur_in       = cur_ff;
      bucket_in    = bucket_ff;
      idx_in       = idx_ff;
      res_kind_in  = res_kind_ff;
      n_in         = n_ff;
      scan_in      = scan_ff;
      keep_in      = keep_ff;
      k_in         = k_ff;
      pend_vld_in  = pend_vld_ff;
      pend_sess_in = pend_sess_ff;
      pend_gen_in  = pend_gen_ff;
      present_in   = present_ff;
      fill_vld_in  = fill_vld_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sess_in  = rsp_sess_ff;
      rsp_gen_in   = rsp_gen_ff;
      rsp_last_in  = rsp_last_ff;
      slot_re      = 1'b0;
      slot_raddr   = {bucket_ff, scan_ff[IW-1:0]};
      slot_we      = 1'b0;
      slot_waddr   = {bucket_ff, keep_ff[IW-1:0]};
      slot_wdata   = slot_rd_ff;
      place_re     = 1'b0;
      place_raddr  = sess_ff[SW-1:0];
      place_we     = 1'b0;
      place_waddr  = slot_rd_ff.sess[SW-1:0];
      place_wdata  = {bucket_ff, keep_ff[IW-1:0]};
      fill_re      = 1'b0;
      fill_raddr   = bucket_ff;
      fill_we      = 1'b0;
      fill_waddr   = bucket_ff;
      fill_wdata   = keep_ff;

      if (csr_wr_en) begin
         cur_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in       = req_tuser;
               sess_in     = req_sess;
               gen_in      = req_tdata[39:8];
               dead_in     = req_tdata[79:40];
               res_kind_in = KIND_ACCEPTED;
               case (req_tuser) inside
                  REQ_ADVANCE: begin
                     cur_in   = cur_ff + TICK_W'(1);
                     state_in = ST_ADV_FILL;
                  end
                  REQ_SCHEDULE, REQ_CANCEL: begin
                     if (32'(req_sess) >= SESSIONS) begin
                        res_kind_in = (req_tuser == REQ_SCHEDULE) ? KIND_REJECTED
                                                                  : KIND_ACCEPTED;
                        state_in    = ST_RESULT;
                     end else if (present_ff[req_sess[SW-1:0]]) begin
                        state_in = ST_DROP_PLACE;
                     end else begin
                        state_in = (req_tuser == REQ_SCHEDULE) ? ST_FILE_FILL : ST_RESULT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DROP_PLACE: begin
            place_re = 1'b1;
            state_in = ST_DROP_FILL;
         end
         ST_DROP_FILL: begin
            bucket_in  = place_rd_ff[PL_W-1:IW];
            idx_in     = place_rd_ff[IW-1:0];
            fill_re    = 1'b1;
            fill_raddr = place_rd_ff[PL_W-1:IW];
            state_in   = ST_DROP_LAST;
         end
         ST_DROP_LAST: begin
            present_in[sess_ff[SW-1:0]] = 1'b0;
            state_in = (op_ff == REQ_SCHEDULE) ? ST_FILE_FILL : ST_RESULT;
            if (fill_cur != '0) begin
               fill_we    = 1'b1;
               fill_wdata = lastidx;
               fill_vld_in[bucket_ff] = 1'b1;
               if (FW'(idx_ff) < lastidx) begin
                  slot_re    = 1'b1;
                  slot_raddr = {bucket_ff, lastidx[IW-1:0]};
                  state_in   = ST_DROP_MOVE;
               end
            end
         end
         ST_DROP_MOVE: begin
            slot_we     = 1'b1;
            slot_waddr  = {bucket_ff, idx_ff};
            place_we    = moved_ok;
            place_wdata = {bucket_ff, idx_ff};
            state_in    = (op_ff == REQ_SCHEDULE) ? ST_FILE_FILL : ST_RESULT;
         end
         ST_FILE_FILL: begin
            due_in     = due_calc;
            bucket_in  = due_calc[BKT_W-1:0];
            fill_re    = 1'b1;
            fill_raddr = due_calc[BKT_W-1:0];
            state_in   = ST_FILE_WR;
         end
         ST_FILE_WR: begin
            state_in = ST_RESULT;
            if (fill_cur >= FW'(SLOTS_PER_BUCKET)) begin
               res_kind_in = KIND_REJECTED;
            end else begin
               slot_we         = 1'b1;
               slot_waddr      = {bucket_ff, fill_cur[IW-1:0]};
               slot_wdata.due  = due_ff;
               slot_wdata.gen  = gen_ff;
               slot_wdata.sess = sess_ff;
               place_we        = s_ok;
               place_waddr     = sess_ff[SW-1:0];
               place_wdata     = {bucket_ff, fill_cur[IW-1:0]};
               fill_we         = 1'b1;
               fill_wdata      = fill_cur + FW'(1);
               fill_vld_in[bucket_ff] = 1'b1;
               present_in[sess_ff[SW-1:0]] = 1'b1;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = res_kind_ff;
               rsp_sess_in = '0;
               rsp_gen_in  = '0;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_ADV_FILL: begin
            bucket_in  = cur_ff[BKT_W-1:0];
            fill_re    = 1'b1;
            fill_raddr = cur_ff[BKT_W-1:0];
            state_in   = ST_ADV_START;
         end
         ST_ADV_START: begin
            n_in        = (fill_cur > FW'(SLOTS_PER_BUCKET)) ? FW'(SLOTS_PER_BUCKET) : fill_cur;
            scan_in     = '0;
            keep_in     = '0;
            k_in        = '0;
            pend_vld_in = 1'b0;
            state_in    = (fill_cur == '0) ? ST_SCAN_END : ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            slot_re  = 1'b1;
            state_in = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            if (!(expire && pend_vld_ff && !out_free)) begin
               if (expire) begin
                  if (pend_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_kind_in = KIND_EXPIRED;
                     rsp_sess_in = pend_sess_ff;
                     rsp_gen_in  = pend_gen_ff;
                     rsp_last_in = 1'b0;
                  end
                  pend_vld_in  = 1'b1;
                  pend_sess_in = slot_rd_ff.sess;
                  pend_gen_in  = slot_rd_ff.gen;
                  k_in         = k_ff + KCNT_W'(1);
                  if (exp_ok) begin
                     present_in[slot_rd_ff.sess[SW-1:0]] = 1'b0;
                  end
               end else begin
                  slot_we  = 1'b1;
                  place_we = exp_ok;
                  keep_in  = keep_ff + FW'(1);
               end
               scan_in  = scan_ff + FW'(1);
               state_in = (scan_ff + FW'(1) == n_ff) ? ST_SCAN_END : ST_SCAN_RD;
            end
         end
         ST_SCAN_END: begin
            if (out_free) begin
               fill_we     = 1'b1;
               fill_vld_in[bucket_ff] = 1'b1;
               rsp_vld_in  = 1'b1;
               rsp_kind_in = pend_vld_ff ? KIND_EXPIRED : KIND_NO_EXP;
               rsp_sess_in = pend_vld_ff ? pend_sess_ff : '0;
               rsp_gen_in  = pend_vld_ff ? pend_gen_ff : '0;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cur_ff      <= '0;
         present_ff  <= '0;
         fill_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         k_ff        <= '0;
         n_ff        <= '0;
         scan_ff     <= '0;
         keep_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         cur_ff      <= cur_in;
         present_ff  <= present_in;
         fill_vld_ff <= fill_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         pend_vld_ff <= pend_vld_in;
         k_ff        <= k_in;
         n_ff        <= n_in;
         scan_ff     <= scan_in;
         keep_ff     <= keep_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sess_ff      <= sess_in;
      gen_ff       <= gen_in;
      dead_ff      <= dead_in;
      due_ff       <= due_in;
      bucket_ff    <= bucket_in;
      idx_ff       <= idx_in;
      res_kind_ff  <= res_kind_in;
      pend_sess_ff <= pend_sess_in;
      pend_gen_ff  <= pend_gen_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_sess_ff  <= rsp_sess_in;
      rsp_gen_ff   <= rsp_gen_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[slot_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (place_we) begin
         place_mem[place_waddr] <= place_wdata;
      end
      if (place_re) begin
         place_rd_ff <= place_mem[place_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      if (fill_re) begin
         fill_rd_ff <= fill_mem[fill_raddr];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_gen_ff, rsp_sess_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `HTW_ASSERT_NOW(a_exp_cap, clock, reset, 1'b1, k_ff <= KCNT_W'(MAX_RESULTS), "expiry count above cap")
   `HTW_ASSERT_NOW(a_scan_idx, clock, reset, state_ff == ST_SCAN_EV, scan_ff < n_ff && keep_ff <= scan_ff, "scan index out of bucket")
   `HTW_ASSERT_NOW(a_noexp_last, clock, reset, rsp_vld_ff && rsp_kind_ff == KIND_NO_EXP, rsp_last_ff && rsp_sess_ff == '0, "idle tick response malformed")
   `HTW_ASSERT_NEXT(a_end_idle, clock, reset, state_ff == ST_SCAN_END && out_free, state_ff == ST_IDLE && rsp_vld_ff && rsp_last_ff, "tick did not close with last")

endmodule
